>>> rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and functions of the SHA-256 hash engine: the
// controller states, the command and status groups between controller and
// datapath, the round constants, the initial hash words and the sigma functions.
// ----------------------------------------------------------------------------
package sha_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_ABSORB      = 2'd0;
  localparam logic [1:0] OP_FINISH_BYTE = 2'd1;
  localparam logic [1:0] OP_FINISH      = 2'd2;

  // Padding constants.
  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [5:0] FILL_LAST     = 6'd63;
  localparam logic [5:0] FILL_LENGTH   = 6'd56;
  localparam logic [5:0] ROUND_LAST    = 6'd63;
  localparam logic [2:0] WORD_LAST     = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // Source of the byte that goes into the block buffer.
  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      push;       // write one byte into the block
    byte_sel_t byte_sel;
    logic      count_bits; // add one message byte to the bit length
    logic      shift_len;  // move the next length byte to the top
    logic      load_work;  // copy chaining value into working variables
    logic      round;      // run one compression round
    logic [5:0] round_idx;
    logic      update;     // fold working variables into chaining value
    logic      restart;    // return to the initial hash value
    logic [2:0] word_idx;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } status_t;

  function automatic logic [31:0] initial_hash(input logic [2:0] idx);
    logic [31:0] h;
    unique case (idx)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      3'd7: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

endpackage

>>> rtl/sha_msg_if.sv
// ----------------------------------------------------------------------------
// sha_msg_if
// Message channel: one beat carries an operation code and a message byte.
// ----------------------------------------------------------------------------
interface sha_msg_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

>>> rtl/sha_digest_if.sv
// ----------------------------------------------------------------------------
// sha_digest_if
// Digest channel: one beat carries one 32-bit word of the hash value.
// ----------------------------------------------------------------------------
interface sha_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

>>> rtl/sha256_hash.sv
// ----------------------------------------------------------------------------
// sha256_hash
// SHA-256 hash engine over a byte stream, with a digest of eight words.
// ----------------------------------------------------------------------------
// Each message beat absorbs a byte, absorbs a byte and finishes, or finishes
// alone. Bytes are taken one per cycle while no compression runs; the 64th
// byte of a block starts the compression, 64 rounds on the single round unit
// and then the chaining update, during which no beat is taken. A finish pads
// one byte per cycle, with one step that pushes nothing before the length
// bytes (up to 64 pad bytes in one block, or up to 72 over two blocks with an
// extra compression when the message fill is 56 or more), compresses the last
// block, and then presents the eight digest words, word 0 first, one beat per
// cycle while the sink is ready. After the eighth word the engine starts a
// new message from the initial hash value. Operation code 3 is taken and
// ignored.
// ----------------------------------------------------------------------------
module sha256_hash
  import sha_pkg::*;
(
  input logic        clk,
  input logic        rst,
  sha_msg_if.sink    msg,
  sha_digest_if.source digest
);

  cmd_t    cmd;
  status_t status;

  sha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (msg.valid),
    .opcode    (msg.opcode),
    .in_ready  (msg.ready),
    .out_valid (digest.valid),
    .out_ready (digest.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sha_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (msg.data_byte),
    .status      (status),
    .digest_word (digest.digest_word),
    .word_index  (digest.word_index),
    .last_word   (digest.last_word)
  );

endmodule

>>> rtl/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// Controller of the hash engine. Sequences byte absorption, padding, the
// 64 compression rounds, the chaining update and the digest output beats.
// ----------------------------------------------------------------------------
module sha_ctrl
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] opcode,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  status_t    status,
  output cmd_t       cmd
);

  state_t     state, state_next;
  state_t     after, after_next;
  logic [5:0] round_cnt, round_cnt_next;
  logic [2:0] word_cnt, word_cnt_next;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      after     <= ST_IDLE;
      round_cnt <= '0;
      word_cnt  <= '0;
    end else begin
      state     <= state_next;
      after     <= after_next;
      round_cnt <= round_cnt_next;
      word_cnt  <= word_cnt_next;
    end
  end

  // Next state and commands.
  always_comb begin
    logic block_full;
    block_full     = (status.fill == FILL_LAST);
    state_next     = state;
    after_next     = after;
    round_cnt_next = round_cnt;
    word_cnt_next  = word_cnt;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd            = '0;
    cmd.byte_sel   = SEL_DATA;
    cmd.round_idx  = round_cnt;
    cmd.word_idx   = word_cnt;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (opcode)
            OP_ABSORB, OP_FINISH_BYTE: begin
              cmd.push       = 1'b1;
              cmd.count_bits = 1'b1;
              if (block_full) begin
                cmd.load_work  = 1'b1;
                round_cnt_next = '0;
                state_next     = ST_ROUND;
                after_next     = (opcode == OP_FINISH_BYTE) ? ST_PAD_MARK : ST_IDLE;
              end else if (opcode == OP_FINISH_BYTE) begin
                state_next = ST_PAD_MARK;
              end
            end
            OP_FINISH: state_next = ST_PAD_MARK;
            default: ;
          endcase
        end
      end

      // The 0x80 marker byte always comes first.
      ST_PAD_MARK: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = SEL_MARK;
        state_next   = ST_PAD_ZERO;
        if (block_full) begin
          cmd.load_work  = 1'b1;
          round_cnt_next = '0;
          state_next     = ST_ROUND;
          after_next     = ST_PAD_ZERO;
        end
      end

      // Zero bytes up to the length field, spilling into a new block if needed.
      ST_PAD_ZERO: begin
        if (status.fill == FILL_LENGTH) begin
          state_next = ST_PAD_LEN;
        end else begin
          cmd.push     = 1'b1;
          cmd.byte_sel = SEL_ZERO;
          if (block_full) begin
            cmd.load_work  = 1'b1;
            round_cnt_next = '0;
            state_next     = ST_ROUND;
            after_next     = ST_PAD_ZERO;
          end
        end
      end

      // Eight big-endian length bytes close the final block.
      ST_PAD_LEN: begin
        cmd.push      = 1'b1;
        cmd.byte_sel  = SEL_LEN;
        cmd.shift_len = 1'b1;
        if (block_full) begin
          cmd.load_work  = 1'b1;
          round_cnt_next = '0;
          state_next     = ST_ROUND;
          after_next     = ST_EMIT;
        end
      end

      ST_ROUND: begin
        cmd.round = 1'b1;
        if (round_cnt == ROUND_LAST) begin
          state_next = ST_UPDATE;
        end else begin
          round_cnt_next = round_cnt + 6'd1;
        end
      end

      ST_UPDATE: begin
        cmd.update    = 1'b1;
        word_cnt_next = '0;
        state_next    = after;
      end

      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          word_cnt_next = word_cnt + 3'd1;
          if (word_cnt == WORD_LAST) begin
            cmd.restart = 1'b1;
            state_next  = ST_IDLE;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/sha_datapath.sv
// ----------------------------------------------------------------------------
// sha_datapath
// Datapath of the hash engine: byte packing into the 16-word schedule
// window, the message bit length, the round logic with working variables
// and the chaining value.
// ----------------------------------------------------------------------------
module sha_datapath
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [7:0]  data_byte,
  output status_t     status,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  logic [31:0] hv   [8];
  logic [31:0] work [8];
  logic [31:0] win  [16];
  logic [23:0] acc;
  logic [5:0]  fill;
  logic [63:0] bits;

  logic [7:0]  byte_val;
  logic [31:0] t1, t2, ch, maj, w_new;

  // Byte source for the block.
  always_comb begin
    unique case (cmd.byte_sel)
      SEL_DATA: byte_val = data_byte;
      SEL_MARK: byte_val = PAD_MARK_BYTE;
      SEL_ZERO: byte_val = 8'h00;
      SEL_LEN:  byte_val = bits[63:56];
      default:  byte_val = 8'h00;
    endcase
  end

  // Round function and next schedule word.
  always_comb begin
    ch    = (work[4] & work[5]) ^ (~work[4] & work[6]);
    maj   = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    t1    = work[7] + big_sigma1(work[4]) + ch + round_k(cmd.round_idx) + win[0];
    t2    = big_sigma0(work[0]) + maj;
    w_new = win[0] + small_sigma0(win[1]) + win[9] + small_sigma1(win[14]);
  end

  // Fill count, bit length and chaining value.
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      fill <= '0;
      bits <= '0;
      for (int i = 0; i < 8; i++) begin
        hv[i] <= initial_hash(3'(i));
      end
    end else begin
      if (cmd.push) begin
        fill <= fill + 6'd1;
      end
      if (cmd.shift_len) begin
        bits <= {bits[55:0], 8'h00};
      end else if (cmd.count_bits) begin
        bits <= bits + 64'd8;
      end
      if (cmd.update) begin
        for (int i = 0; i < 8; i++) begin
          hv[i] <= hv[i] + work[i];
        end
      end
    end
  end

  // Byte packing and the schedule window, which shifts on every word.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (fill[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          win[i] <= win[i+1];
        end
        win[15] <= {acc, byte_val};
      end else begin
        acc <= {acc[15:0], byte_val};
      end
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w_new;
    end
  end

  // Working variables.
  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      for (int i = 0; i < 8; i++) begin
        work[i] <= hv[i];
      end
    end else if (cmd.round) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

  assign status.fill = fill;
  assign digest_word = hv[cmd.word_idx];
  assign word_index  = cmd.word_idx;
  assign last_word   = (cmd.word_idx == WORD_LAST);

endmodule
